// ===== sv/ipv6_route_table_lpm_core_assert.svh =====
// assertion macros for the route table core
`ifndef IPV6_ROUTE_TABLE_LPM_CORE_ASSERT_SVH
`define IPV6_ROUTE_TABLE_LPM_CORE_ASSERT_SVH
`ifndef SYNTH
`define RT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define RT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RT_ASSERT(label, clk, rst_n, prop)
`define RT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rtl_pkg.sv =====
// ----------------------------------------------------------------------------
// route table package
// types, constants and helpers shared by the route table core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rtl_pkg;
	localparam int TableEntries = 8;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = $clog2(TableEntries + 1);
	localparam logic [7:0] FullMatch = 8'd128;
	localparam logic [19:0] TicksReset = 20'd1000;

	// entry word: prefix hi/lo, length, gateway hi/lo, gw valid, iface, expiry, permanent
	localparam int EntryW = 64 + 64 + 8 + 64 + 64 + 1 + 8 + 32 + 1;

	typedef enum logic [1:0] {
		REQ_PUT = 2'd0,
		REQ_DEL = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_TICK = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_MUL,
		FSM_SCAN,
		FSM_WRITE,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic [63:0] pfx_hi;
		logic [63:0] pfx_lo;
		logic [7:0] pfx_len;
		logic [63:0] gw_hi;
		logic [63:0] gw_lo;
		logic gw_valid;
		logic [7:0] iface;
		logic [31:0] expiry;
		logic perm;
	} entry_t;

	// leading common bits of two 128-bit values, given their xor
	function automatic logic [7:0] shared_bits(input logic [127:0] d);
		logic [7:0] n;
		logic found;
		n = 8'd128;
		found = 1'b0;
		for (int i = 127; i >= 0; i--) begin
			if (d[i] && !found) begin
				n = 8'(127 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction
endpackage

// ===== sv/rtl_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// single port write, single port read, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rtl_ram #(
	parameter int Width = 8,
	parameter int Depth = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/rtl_ctrl.sv =====
// ----------------------------------------------------------------------------
// route table controller
// scans the entry ram one entry per cycle and answers each request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv6_route_table_lpm_core_assert.svh"
module rtl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [19:0] cfg_data,
	input logic req_valid,
	output logic req_ready,
	input logic [1:0] req_type,
	input logic [127:0] req_addr,
	input logic [7:0] req_len,
	input logic [127:0] req_hop,
	input logic req_hop_present,
	input logic [7:0] req_iface,
	input logic [15:0] req_life,
	input logic req_never,
	output logic res_valid,
	input logic res_ready,
	output logic [1:0] res_status,
	output logic [2:0] res_slot,
	output logic [127:0] res_hop,
	output logic [7:0] res_iface,
	output logic ram_we,
	output logic [rtl_pkg::IdxW-1:0] ram_waddr,
	output rtl_pkg::entry_t ram_wdata,
	output logic [rtl_pkg::IdxW-1:0] ram_raddr,
	input rtl_pkg::entry_t ram_rdata
);
	import rtl_pkg::*;

	fsm_t state_q, state_d;
	logic [19:0] tps_q;
	logic [31:0] now_q;
	logic [TableEntries-1:0] used_q;
	logic [CntW-1:0] rd_cnt_q;
	logic [IdxW-1:0] chk_idx_q;
	logic chk_vld_q;
	logic [1:0] type_q;
	logic [127:0] addr_q, hop_q;
	logic [7:0] len_q, iface_q;
	logic hop_pres_q, never_q;
	logic [15:0] life_q;
	logic [31:0] prod_q;
	logic found_q, free_found_q, stop_q;
	logic [IdxW-1:0] found_idx_q, free_idx_q;
	logic [7:0] best_len_q;
	logic [127:0] best_hop_q;
	logic best_gw_q;
	logic [7:0] best_iface_q;
	logic out_vld_q;
	logic [1:0] out_status_q;
	logic [2:0] out_slot_q;
	logic [127:0] out_hop_q;
	logic [7:0] out_iface_q;

	logic scan_last;
	logic [7:0] m;
	logic expired, live, exact, qual;

	assign req_ready = (state_q == FSM_IDLE) && !out_vld_q;
	assign res_valid = out_vld_q;
	assign res_status = out_status_q;
	assign res_slot = out_slot_q;
	assign res_hop = out_hop_q;
	assign res_iface = out_iface_q;
	assign ram_raddr = rd_cnt_q[IdxW-1:0];

	// compare the entry read in the previous cycle
	assign m = shared_bits(addr_q ^ {ram_rdata.pfx_hi, ram_rdata.pfx_lo});
	assign expired = !ram_rdata.perm && (now_q > ram_rdata.expiry);
	assign live = chk_vld_q && used_q[chk_idx_q] && !stop_q;
	assign exact = live && ram_rdata.pfx_len == len_q
		&& {ram_rdata.pfx_hi, ram_rdata.pfx_lo} == addr_q;
	assign qual = live && !expired && m >= ram_rdata.pfx_len;
	assign scan_last = chk_vld_q && (chk_idx_q == IdxW'(TableEntries - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (req_valid && req_ready) state_d = FSM_MUL;
			FSM_MUL: state_d = FSM_SCAN;
			FSM_SCAN: if (scan_last) state_d = FSM_WRITE;
			FSM_WRITE: state_d = FSM_DONE;
			FSM_DONE: state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			tps_q <= TicksReset;
			now_q <= '0;
			used_q <= '0;
			out_vld_q <= 1'b0;
			rd_cnt_q <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tps_q <= cfg_data;
			if (out_vld_q && res_ready) out_vld_q <= 1'b0;
			if (state_q == FSM_MUL) begin
				rd_cnt_q <= CntW'(1);
				chk_vld_q <= 1'b1;
			end else if (state_q == FSM_SCAN) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				chk_vld_q <= !scan_last;
			end else begin
				rd_cnt_q <= '0;
				chk_vld_q <= 1'b0;
			end
			if (state_q == FSM_WRITE) begin
				unique case (req_t'(type_q))
					REQ_PUT: if (found_q || free_found_q)
						used_q[found_q ? found_idx_q : free_idx_q] <= 1'b1;
					REQ_DEL: if (found_q) used_q[found_idx_q] <= 1'b0;
					REQ_TICK: now_q <= now_q + 32'd1;
					default: ;
				endcase
			end
			if (state_q == FSM_DONE) out_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			type_q <= req_type;
			addr_q <= req_addr;
			len_q <= req_len;
			hop_q <= req_hop;
			hop_pres_q <= req_hop_present;
			iface_q <= req_iface;
			life_q <= req_life;
			never_q <= req_never;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			stop_q <= 1'b0;
			best_len_q <= '0;
		end
		if (state_q == FSM_MUL) prod_q <= 32'(life_q * tps_q);
		if (state_q == FSM_SCAN && chk_vld_q && !stop_q) begin
			if (!used_q[chk_idx_q]) begin
				if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q <= chk_idx_q;
				end
			end else if (type_q == REQ_LOOKUP) begin
				if (qual && (!found_q || m > best_len_q)) begin
					found_q <= 1'b1;
					found_idx_q <= chk_idx_q;
					best_len_q <= m;
					best_gw_q <= ram_rdata.gw_valid;
					best_hop_q <= {ram_rdata.gw_hi, ram_rdata.gw_lo};
					best_iface_q <= ram_rdata.iface;
				end
				if (qual && m == FullMatch) stop_q <= 1'b1;
			end else if (exact) begin
				found_q <= 1'b1;
				found_idx_q <= chk_idx_q;
				stop_q <= 1'b1;
			end
		end
		if (state_q == FSM_SCAN) chk_idx_q <= rd_cnt_q[IdxW-1:0];
		if (state_q == FSM_MUL) chk_idx_q <= '0;
		if (state_q == FSM_WRITE) begin
			unique case (req_t'(type_q))
				REQ_PUT: begin
					out_status_q <= (found_q || free_found_q) ? ST_OK : ST_FULL;
					out_slot_q <= found_q ? 3'(found_idx_q) :
						free_found_q ? 3'(free_idx_q) : 3'd0;
					out_hop_q <= '0;
					out_iface_q <= '0;
				end
				REQ_DEL: begin
					out_status_q <= found_q ? ST_OK : ST_NOT_FOUND;
					out_slot_q <= found_q ? 3'(found_idx_q) : 3'd0;
					out_hop_q <= '0;
					out_iface_q <= '0;
				end
				REQ_LOOKUP: begin
					out_status_q <= found_q ? ST_OK : ST_NOT_FOUND;
					out_slot_q <= found_q ? 3'(found_idx_q) : 3'd0;
					out_hop_q <= !found_q ? 128'd0 : best_gw_q ? best_hop_q : addr_q;
					out_iface_q <= found_q ? best_iface_q : 8'd0;
				end
				REQ_TICK: begin
					out_status_q <= ST_OK;
					out_slot_q <= '0;
					out_hop_q <= '0;
					out_iface_q <= '0;
				end
			endcase
		end
	end

	// entry write back; prefix is rewritten unchanged on an update
	always_comb begin
		ram_we = (state_q == FSM_WRITE) && (type_q == REQ_PUT) && (found_q || free_found_q);
		ram_waddr = found_q ? found_idx_q : free_idx_q;
		ram_wdata.pfx_hi = addr_q[127:64];
		ram_wdata.pfx_lo = addr_q[63:0];
		ram_wdata.pfx_len = len_q;
		ram_wdata.gw_valid = hop_pres_q;
		ram_wdata.gw_hi = hop_pres_q ? hop_q[127:64] : 64'd0;
		ram_wdata.gw_lo = hop_pres_q ? hop_q[63:0] : 64'd0;
		ram_wdata.iface = iface_q;
		ram_wdata.perm = never_q;
		ram_wdata.expiry = never_q ? 32'd0 : now_q + prod_q;
	end

	`RT_ASSERT(a_ready_idle, clk, arst_n, !req_ready || (state_q == FSM_IDLE))
	`RT_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == FSM_DONE, out_vld_q)
	`RT_ASSERT_NEXT(a_write_done, clk, arst_n, state_q == FSM_WRITE, state_q == FSM_DONE)
	`RT_ASSERT(a_we_put, clk, arst_n, !ram_we || (type_q == REQ_PUT))
endmodule

// ===== sv/ipv6_route_table_lpm_core.sv =====
// ----------------------------------------------------------------------------
// ipv6 route table core
// eight-entry longest-prefix-match table with route lifetimes
// ----------------------------------------------------------------------------
// Each request word goes through the states in order: the multiply state
// computes the lifetime while the first entry is read, the scan state compares
// all eight entries as they come out of the single registered read port of the
// entry ram, the write state writes back, and the done state presents the result.
// One request is handled at a time; the next is taken once the previous result
// word has been taken.
`timescale 1ns / 1ps
module ipv6_route_table_lpm_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [19:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// req_type, addr_hi, addr_lo, pfx_length, hop_hi, hop_lo, hop_present,
	// out_iface, life_seconds, never_expires; zero pad to 296 bits
	input logic [295:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status, slot, result_hop_hi, result_hop_lo, result_iface; pad to 144 bits
	output logic [143:0] m_tdata
);
	import rtl_pkg::*;

	logic ram_we;
	logic [IdxW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;
	logic [1:0] res_status;
	logic [2:0] res_slot;
	logic [127:0] res_hop;
	logic [7:0] res_iface;

	rtl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req_type(s_tdata[1:0]),
		.req_addr({s_tdata[65:2], s_tdata[129:66]}),
		.req_len(s_tdata[137:130]),
		.req_hop({s_tdata[201:138], s_tdata[265:202]}),
		.req_hop_present(s_tdata[266]),
		.req_iface(s_tdata[274:267]),
		.req_life(s_tdata[290:275]),
		.req_never(s_tdata[291]),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_status(res_status),
		.res_slot(res_slot),
		.res_hop(res_hop),
		.res_iface(res_iface),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	rtl_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tdata = {3'b0, res_iface, res_hop[63:0], res_hop[127:64], res_slot, res_status};
endmodule
